// ----- rtl/core/cbpb_pkg.sv -----
`timescale 1ns / 1ps
package cbpb_pkg;

  // operation group, op bits 7..6
  typedef enum logic [1:0] {
    GRP_SHIFT = 2'd0,
    GRP_BIT   = 2'd1,
    GRP_RES   = 2'd2,
    GRP_SET   = 2'd3
  } grp_e;

  // rotate/shift/swap selector, op bits 5..3 in the shift group
  typedef enum logic [2:0] {
    SH_RLC  = 3'd0,
    SH_RRC  = 3'd1,
    SH_RL   = 3'd2,
    SH_RR   = 3'd3,
    SH_SLA  = 3'd4,
    SH_SRA  = 3'd5,
    SH_SWAP = 3'd6,
    SH_SRL  = 3'd7
  } shift_e;

  // register file slots, order B,C,D,E,H,L,F,A
  localparam logic [2:0] REG_H    = 3'd4;
  localparam logic [2:0] REG_L    = 3'd5;
  localparam logic [2:0] REG_F    = 3'd6;
  localparam logic [2:0] OPND_MEM = 3'd6;
  localparam int unsigned NUM_REGS = 8;

  // flag bit positions inside F
  localparam int unsigned FLAG_Z = 7;
  localparam int unsigned FLAG_N = 6;
  localparam int unsigned FLAG_H = 5;
  localparam int unsigned FLAG_C = 4;

  localparam logic [4:0] CYC_REG     = 5'd8;
  localparam logic [4:0] CYC_BIT_MEM = 5'd12;
  localparam logic [4:0] CYC_MEM     = 5'd16;

  // reset contents, slot 7 (A) leftmost down to slot 0 (B)
  localparam logic [NUM_REGS-1:0][7:0] RF_RESET = {
    8'h01, 8'hB0, 8'h4D, 8'h01, 8'hD8, 8'h00, 8'h13, 8'h00
  };

  typedef struct packed {
    logic [7:0] op;
    logic [7:0] mem_value;
  } cbpb_in_t;

  typedef struct packed {
    logic [7:0]  result_value;
    logic [3:0]  flags_out;
    logic        mem_write;
    logic [15:0] mem_address;
    logic [4:0]  cycle_count;
  } cbpb_out_t;

  // classified instruction as it travels from front to back
  typedef struct packed {
    grp_e       grp;
    logic [2:0] sel;
    logic [2:0] code;
    logic       is_mem;
    logic       mem_wr;
    logic [4:0] cycles;
    logic [7:0] mem_value;
  } cbpb_dec_t;

endpackage

// ----- rtl/core/cbpb_front.sv -----
`timescale 1ns / 1ps
module cbpb_front import cbpb_pkg::*; (
  input  cbpb_in_t  item_i,
  output cbpb_dec_t dec_o
);

  logic is_mem;
  logic is_bit;

  assign is_mem = (item_i.op[2:0] == OPND_MEM);
  assign is_bit = (grp_e'(item_i.op[7:6]) == GRP_BIT);

  always_comb begin
    dec_o.grp       = grp_e'(item_i.op[7:6]);
    dec_o.sel       = item_i.op[5:3];
    dec_o.code      = item_i.op[2:0];
    dec_o.is_mem    = is_mem;
    dec_o.mem_wr    = is_mem && !is_bit;
    dec_o.mem_value = item_i.mem_value;
    if (!is_mem) begin
      dec_o.cycles = CYC_REG;
    end else if (is_bit) begin
      dec_o.cycles = CYC_BIT_MEM;
    end else begin
      dec_o.cycles = CYC_MEM;
    end
  end

endmodule

// ----- rtl/core/cbpb_queue.sv -----
`timescale 1ns / 1ps
module cbpb_queue import cbpb_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  cbpb_dec_t push_data_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output cbpb_dec_t pop_data_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cbpb_dec_t       entry_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_ready_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // payload slots carry no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/core/cbpb_back.sv -----
`timescale 1ns / 1ps
module cbpb_back import cbpb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      dec_valid_i,
  output logic      dec_ready_o,
  input  cbpb_dec_t dec_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output cbpb_out_t out_data_o
);

  logic [7:0] rf_q [NUM_REGS];
  logic       out_valid_q;
  cbpb_out_t  out_q, out_d;
  logic       take;
  logic [7:0] opnd, f_cur, f_new, res, sh_res;
  logic       sh_cout, carry_in, tested;

  assign dec_ready_o = !out_valid_q || out_ready_i;
  assign take        = dec_valid_i && dec_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign opnd     = dec_i.is_mem ? dec_i.mem_value : rf_q[dec_i.code];
  assign f_cur    = rf_q[REG_F];
  assign carry_in = f_cur[FLAG_C];
  assign tested   = opnd[dec_i.sel];

  // rotate / shift / swap
  always_comb begin
    sh_res  = opnd;
    sh_cout = 1'b0;
    case (shift_e'(dec_i.sel))
      SH_RLC:  begin sh_res = {opnd[6:0], opnd[7]};   sh_cout = opnd[7]; end
      SH_RRC:  begin sh_res = {opnd[0], opnd[7:1]};   sh_cout = opnd[0]; end
      SH_RL:   begin sh_res = {opnd[6:0], carry_in};  sh_cout = opnd[7]; end
      SH_RR:   begin sh_res = {carry_in, opnd[7:1]};  sh_cout = opnd[0]; end
      SH_SLA:  begin sh_res = {opnd[6:0], 1'b0};      sh_cout = opnd[7]; end
      SH_SRA:  begin sh_res = {opnd[7], opnd[7:1]};   sh_cout = opnd[0]; end
      SH_SWAP: begin sh_res = {opnd[3:0], opnd[7:4]}; sh_cout = 1'b0;    end
      SH_SRL:  begin sh_res = {1'b0, opnd[7:1]};      sh_cout = opnd[0]; end
      default: begin sh_res = opnd;                   sh_cout = 1'b0;    end
    endcase
  end

  always_comb begin
    res   = opnd;
    f_new = {f_cur[7:4], 4'b0000};
    case (dec_i.grp)
      GRP_SHIFT: begin
        res   = sh_res;
        f_new = {(sh_res == 8'h00), 1'b0, 1'b0, sh_cout, 4'b0000};
      end
      GRP_BIT: begin
        f_new = {!tested, 1'b0, 1'b1, carry_in, 4'b0000};
      end
      GRP_RES: begin
        res = opnd & ~(8'h01 << dec_i.sel);
      end
      GRP_SET: begin
        res = opnd | (8'h01 << dec_i.sel);
      end
      default: begin
        res = opnd;
      end
    endcase
  end

  always_comb begin
    out_d.result_value = res;
    out_d.flags_out    = f_new[7:4];
    out_d.mem_write    = dec_i.mem_wr;
    out_d.mem_address  = dec_i.is_mem ? {rf_q[REG_H], rf_q[REG_L]} : 16'h0000;
    out_d.cycle_count  = dec_i.cycles;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        rf_q[i] <= RF_RESET[i];
      end
    end else begin
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (take) begin
        rf_q[REG_F] <= f_new;
        // memory operand never writes its result to the file, BIT never writes back
        if (!dec_i.is_mem && dec_i.grp != GRP_BIT) begin
          rf_q[dec_i.code] <= res;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- rtl/core/cb_prefix_bit_shift_unit.sv -----
`timescale 1ns / 1ps
// executes one cb-prefixed instruction byte per item against an internal
// B,C,D,E,H,L,F,A register file (reset to 00 13 00 D8 01 4D B0 01).
// one item is accepted per cycle while the queue has room, and its result
// appears once it has passed the decode queue and then the execute stage
// that reads and updates the register file and fills the output register.
// the sustained rate is one item per cycle while the output side keeps up;
// the queue of QUEUE_DEPTH entries absorbs output stalls so the input side
// keeps taking items until full.
// memory-operand instructions (operand code 6) use mem_value and report a
// write to H:L unless the operation is BIT; cycle_count reports the
// architectural timing (8, 12 or 16), not the latency of this block.
module cb_prefix_bit_shift_unit import cbpb_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  cbpb_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output cbpb_out_t out_data_o
);

  // classified item on its way into the queue
  cbpb_dec_t front_dec;
  // head of the queue toward the execute stage
  cbpb_dec_t q_dec;
  logic      q_valid;
  logic      q_ready;

  // front: pure decode of group, selector, operand and timing
  cbpb_front u_front (
    .item_i (in_data_i),
    .dec_o  (front_dec)
  );

  // short queue decoupling acceptance from execution
  cbpb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (front_dec),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_dec)
  );

  // back: register file, alu and output register
  cbpb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dec_valid_i (q_valid),
    .dec_ready_o (q_ready),
    .dec_i       (q_dec),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/core/cbpb_checker.sv -----
`timescale 1ns / 1ps
module cbpb_checker import cbpb_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input cbpb_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input cbpb_out_t out_data_o
);

  // an offered input item waits unchanged until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input item changed while waiting");

  // a stalled item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  // from an empty pipe an item shows up after passing the queue and the execute stage
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("output item without matching input item");

  // memory writes only come with memory timing
  a_mem_write_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.mem_write |-> out_data_o.cycle_count == CYC_MEM)
    else $error("memory write with wrong cycle count");

  // register operands never address memory
  a_reg_no_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.cycle_count == CYC_REG
      |-> !out_data_o.mem_write && out_data_o.mem_address == 16'h0000)
    else $error("register operand produced a memory access");

endmodule

bind cb_prefix_bit_shift_unit cbpb_checker u_cbpb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- dv/cb_prefix_bit_shift_unit_tb.sv -----
`timescale 1ns / 1ps
module cb_prefix_bit_shift_unit_tb;
  import cbpb_pkg::*;

  // receiver stall patterns, picked afresh at random
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HALF,
    RX_HEAVY
  } rx_mode_e;

  localparam int unsigned RANDOM_ITEMS = 1300;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  cbpb_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  cbpb_out_t out_data;

  // instructions still to be offered, and results owed by the block
  cbpb_in_t  queued_instrs[$];
  cbpb_out_t awaited_results[$];
  cbpb_out_t want_res;

  // shadow register file, order B,C,D,E,H,L,F,A
  logic [7:0] shadow_regs [8];

  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_mode_cycles = 0;

  cb_prefix_bit_shift_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // executes one cb instruction on the shadow registers and returns
  // the result item the block owes for it
  function automatic cbpb_out_t execute_cb_op(cbpb_in_t instr);
    grp_e       grp;
    logic [2:0] bsel;
    logic [2:0] code;
    logic       is_mem;
    logic       keeps_result;
    logic [7:0] opnd;
    logic [7:0] res;
    logic [7:0] f_old;
    logic [7:0] f_new;
    logic       carry;
    logic [15:0] hl;
    cbpb_out_t  item;
    grp    = grp_e'(instr.op[7:6]);
    bsel   = instr.op[5:3];
    code   = instr.op[2:0];
    is_mem = (code == OPND_MEM);
    // address is taken before any write-back to H or L
    hl     = {shadow_regs[REG_H], shadow_regs[REG_L]};
    opnd   = is_mem ? instr.mem_value : shadow_regs[code];
    f_old  = shadow_regs[REG_F];
    f_new  = f_old;
    res    = opnd;
    carry  = 1'b0;
    keeps_result = 1'b1;
    case (grp)
      GRP_SHIFT: begin
        case (shift_e'(bsel))
          SH_RLC: begin
            res = {opnd[6:0], opnd[7]};
            carry = opnd[7];
          end
          SH_RRC: begin
            res = {opnd[0], opnd[7:1]};
            carry = opnd[0];
          end
          SH_RL: begin
            res = {opnd[6:0], f_old[FLAG_C]};
            carry = opnd[7];
          end
          SH_RR: begin
            res = {f_old[FLAG_C], opnd[7:1]};
            carry = opnd[0];
          end
          SH_SLA: begin
            res = {opnd[6:0], 1'b0};
            carry = opnd[7];
          end
          SH_SRA: begin
            res = {opnd[7], opnd[7:1]};
            carry = opnd[0];
          end
          SH_SWAP: begin
            res = {opnd[3:0], opnd[7:4]};
            carry = 1'b0;
          end
          SH_SRL: begin
            res = {1'b0, opnd[7:1]};
            carry = opnd[0];
          end
        endcase
        f_new = '0;
        f_new[FLAG_Z] = (res == 8'h00);
        f_new[FLAG_C] = carry;
      end
      GRP_BIT: begin
        // carry survives a bit test
        f_new = '0;
        f_new[FLAG_Z] = ~opnd[bsel];
        f_new[FLAG_H] = 1'b1;
        f_new[FLAG_C] = f_old[FLAG_C];
        keeps_result = 1'b0;
      end
      GRP_RES: res[bsel] = 1'b0;
      GRP_SET: res[bsel] = 1'b1;
    endcase
    f_new[3:0] = 4'h0;
    shadow_regs[REG_F] = f_new;
    if (!is_mem && keeps_result) shadow_regs[code] = res;
    item.result_value = res;
    item.flags_out    = f_new[7:4];
    item.mem_write    = is_mem && keeps_result;
    item.mem_address  = is_mem ? hl : 16'h0000;
    if (!is_mem) item.cycle_count = CYC_REG;
    else if (keeps_result) item.cycle_count = CYC_MEM;
    else item.cycle_count = CYC_BIT_MEM;
    return item;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic add_instr(logic [7:0] op, logic [7:0] mem_value);
    cbpb_in_t instr;
    instr.op = op;
    instr.mem_value = mem_value;
    queued_instrs.push_back(instr);
  endtask

  // sender: bursts of random length, random gaps between them; the
  // prediction is made at the edge where the item is taken
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && in_ready) awaited_results.push_back(execute_cb_op(in_data));
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (queued_instrs.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= queued_instrs.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            // a third of the bursts follow on with no gap at all
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result taken and stalls on its own pattern
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready      <= 1'b0;
      rx_mode        <= RX_OPEN;
      rx_mode_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result item with nothing outstanding: 0x%0h", out_data);
          mismatch_count++;
        end else begin
          want_res = awaited_results.pop_front();
          check_field("result_value", want_res.result_value, out_data.result_value);
          check_field("flags_out", want_res.flags_out, out_data.flags_out);
          check_field("mem_write", want_res.mem_write, out_data.mem_write);
          check_field("mem_address", want_res.mem_address, out_data.mem_address);
          check_field("cycle_count", want_res.cycle_count, out_data.cycle_count);
        end
      end
      if (rx_mode_cycles == 0) begin
        rx_mode        <= rx_mode_e'($urandom_range(0, 3));
        rx_mode_cycles <= $urandom_range(8, 64);
      end else begin
        rx_mode_cycles <= rx_mode_cycles - 1;
      end
      case (rx_mode)
        RX_OPEN:  out_ready <= 1'b1;
        RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
        RX_HALF:  out_ready <= 1'($urandom_range(0, 1));
        RX_HEAVY: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  initial begin
    logic [7:0] op;
    logic [7:0] mem_value;
    shadow_regs[0] = 8'h00;
    shadow_regs[1] = 8'h13;
    shadow_regs[2] = 8'h00;
    shadow_regs[3] = 8'hD8;
    shadow_regs[4] = 8'h01;
    shadow_regs[5] = 8'h4D;
    shadow_regs[6] = 8'hB0;
    shadow_regs[7] = 8'h01;

    // every rotate, shift and swap on the memory operand, with edge bytes
    for (int s = 0; s < 8; s++) begin
      op = {GRP_SHIFT, 3'(s), OPND_MEM};
      case (s % 4)
        0: add_instr(op, 8'h80);
        1: add_instr(op, 8'h01);
        2: add_instr(op, 8'hFF);
        default: add_instr(op, 8'h00);
      endcase
    end
    // bit test on memory: no write, tested byte comes back; then res and set on memory
    add_instr({GRP_BIT, 3'd7, OPND_MEM}, 8'h80);
    add_instr({GRP_BIT, 3'd0, OPND_MEM}, 8'h00);
    add_instr({GRP_RES, 3'd7, OPND_MEM}, 8'hFF);
    add_instr({GRP_SET, 3'd0, OPND_MEM}, 8'h00);
    // register operands, including ones that move H:L, then a bit test on memory
    add_instr({GRP_SHIFT, SH_RL, 3'd7}, 8'hFF);
    add_instr({GRP_SHIFT, SH_RR, 3'd0}, 8'h00);
    add_instr({GRP_BIT, 3'd3, 3'd3}, 8'hFF);
    add_instr({GRP_RES, 3'd4, 3'd7}, 8'h00);
    add_instr({GRP_SET, 3'd7, REG_H}, 8'hFF);
    add_instr({GRP_SHIFT, SH_SWAP, REG_L}, 8'h00);
    add_instr({GRP_SHIFT, SH_SRA, 3'd1}, 8'hFF);
    add_instr({GRP_SHIFT, SH_SLA, 3'd2}, 8'h00);
    add_instr({GRP_BIT, 3'd0, OPND_MEM}, 8'hFF);
    // opcode extremes
    add_instr(8'hFF, 8'hFF);
    add_instr(8'h00, 8'h00);

    // random instructions, a quarter of them forced onto memory
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      op = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) op[2:0] = OPND_MEM;
      case ($urandom_range(0, 7))
        0: mem_value = 8'h00;
        1: mem_value = 8'hFF;
        default: mem_value = 8'($urandom_range(0, 255));
      endcase
      add_instr(op, mem_value);
    end

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // drain: everything offered, everything owed has come back
    while (queued_instrs.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    // linger to catch stray results
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
